// ===== rtl/core/tss_pkg.sv =====
// Package for the TDMA superframe slot timer: types, codes and register indexes.
package tss_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_COUNT  = 2'd0,
        CFG_SLOT_LENGTH = 2'd1,
        CFG_FIRST_START = 2'd2,
        CFG_UNUSED      = 2'd3
    } tss_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START1,
        ST_WAIT1,
        ST_START2,
        ST_WAIT2,
        ST_MUL,
        ST_HOLD
    } tss_state_t;

    typedef struct packed {
        logic take;      // latch the accepted input word
        logic div_start; // launch both dividers
        logic stage2;    // operand select for the second division pass
        logic cap1;      // capture first pass results
        logic cap2;      // capture second pass results
        logic mul;       // form the slot offset product
        logic load;      // load the output register, update frame start
    } tss_cmd_t;

    typedef struct packed {
        logic div_done;
    } tss_stat_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [15:0] query_slot;
        logic        advance;
    } tss_item_t;

    typedef struct packed {
        logic [15:0] active_slot;
        logic        frame_elapsed;
        logic [31:0] slot_begin_ms;
        logic [31:0] slot_finish_ms;
        logic [31:0] frame_length_ms;
        logic [31:0] next_frame_start;
    } tss_result_t;

endpackage

// ===== rtl/core/tss_channels.sv =====
// Handshake channel interfaces: input word, result word and configuration write.
interface tss_item_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic [15:0] query_slot;
    logic        advance;

    modport source (output valid, now_ms, query_slot, advance, input ready);
    modport sink   (input valid, now_ms, query_slot, advance, output ready);
endinterface

interface tss_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] active_slot;
    logic        frame_elapsed;
    logic [31:0] slot_begin_ms;
    logic [31:0] slot_finish_ms;
    logic [31:0] frame_length_ms;
    logic [31:0] next_frame_start;

    modport source (output valid, active_slot, frame_elapsed, slot_begin_ms,
                    slot_finish_ms, frame_length_ms, next_frame_start, input ready);
    modport sink   (input valid, active_slot, frame_elapsed, slot_begin_ms,
                    slot_finish_ms, frame_length_ms, next_frame_start, output ready);
endinterface

interface tss_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tss_divider.sv =====
// Iterative 32-bit restoring divider, one quotient bit per cycle.
module tss_divider
    import tss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic        run_reg, run_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] trial;
    logic [32:0] diff;

    assign trial = {rem_reg, quo_reg[31]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 6'd32;
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            if (cnt_reg == 6'd0)
            begin
                run_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
                if (!diff[32])
                begin
                    rem_next = diff[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = run_reg && (cnt_reg == 6'd0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/tss_datapath.sv =====
// Datapath: configuration, frame start state, two dividers and the result register.
module tss_datapath
    import tss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  tss_item_t   item,
    input  tss_cmd_t    cmd,
    output tss_stat_t   stat,
    output tss_result_t result
);

    logic [15:0] scount_reg;
    logic [15:0] slen_reg;
    logic [31:0] flen_reg;
    logic [31:0] start_reg, start_next;

    logic [31:0] now_reg;
    logic [15:0] qs_reg;
    logic        adv_reg;

    logic [31:0] quo_a1_reg;
    logic [31:0] rem_b1_reg;
    logic [15:0] rem_a2_reg;
    logic [15:0] rem_b2_reg;
    logic [31:0] prod_reg;
    tss_result_t res_reg, res_next;

    logic [31:0] elapsed;
    logic        started;
    logic [15:0] qmod;

    logic [31:0] a_dividend, a_divisor, b_dividend, b_divisor;
    logic        a_done, b_done;
    logic [31:0] a_quo, a_rem, b_quo, b_rem;

    assign elapsed = now_reg - start_reg;
    assign started = now_reg >= start_reg;
    assign qmod    = (scount_reg != 16'd0) ? rem_b2_reg : 16'd0;

    // pass 1: elapsed / slot length, elapsed % frame length
    // pass 2: slot quotient % slot count, query % slot count
    always_comb
    begin
        if (cmd.stage2)
        begin
            a_dividend = quo_a1_reg;
            a_divisor  = {16'd0, scount_reg};
            b_dividend = {16'd0, qs_reg};
            b_divisor  = {16'd0, scount_reg};
        end
        else
        begin
            a_dividend = elapsed;
            a_divisor  = {16'd0, slen_reg};
            b_dividend = elapsed;
            b_divisor  = flen_reg;
        end
    end

    tss_divider u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (a_dividend),
        .divisor   (a_divisor),
        .done      (a_done),
        .quotient  (a_quo),
        .remainder (a_rem)
    );

    tss_divider u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (b_dividend),
        .divisor   (b_divisor),
        .done      (b_done),
        .quotient  (b_quo),
        .remainder (b_rem)
    );

    // both units run in lockstep; quotient of unit b is not needed
    assign stat.div_done = a_done && b_done && (b_quo == b_quo);

    always_comb
    begin
        res_next.active_slot = 16'd0;
        if (started && (slen_reg != 16'd0) && (scount_reg != 16'd0))
        begin
            res_next.active_slot = rem_a2_reg;
        end
        res_next.frame_elapsed   = started && (elapsed >= flen_reg);
        res_next.slot_begin_ms   = start_reg + prod_reg;
        res_next.slot_finish_ms  = start_reg + prod_reg + {16'd0, slen_reg};
        res_next.frame_length_ms = flen_reg;
        // start + passed * flen equals now - (elapsed % flen)
        start_next = start_reg;
        if (adv_reg && (flen_reg != 32'd0))
        begin
            start_next = now_reg - rem_b1_reg + flen_reg;
        end
        res_next.next_frame_start = start_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scount_reg <= 16'd100;
            slen_reg   <= 16'd1000;
            flen_reg   <= 32'd100000;
            start_reg  <= 32'd0;
        end
        else
        begin
            flen_reg <= {16'd0, scount_reg} * {16'd0, slen_reg};
            if (cfg_we)
            begin
                unique case (tss_cfg_idx_t'(cfg_index))
                    CFG_SLOT_COUNT:  scount_reg <= cfg_data[15:0];
                    CFG_SLOT_LENGTH: slen_reg   <= cfg_data[15:0];
                    CFG_FIRST_START: start_reg  <= cfg_data;
                    default:         ;
                endcase
            end
            else if (cmd.load)
            begin
                start_reg <= start_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            now_reg <= item.now_ms;
            qs_reg  <= item.query_slot;
            adv_reg <= item.advance;
        end
        if (cmd.cap1)
        begin
            quo_a1_reg <= a_quo;
            rem_b1_reg <= b_rem;
        end
        if (cmd.cap2)
        begin
            rem_a2_reg <= a_rem[15:0];
            rem_b2_reg <= b_rem[15:0];
        end
        if (cmd.mul)
        begin
            prod_reg <= {16'd0, qmod} * {16'd0, slen_reg};
        end
        if (cmd.load)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

// ===== rtl/core/tss_ctrl.sv =====
// Controller: sequences the two division passes and owns the output valid flag.
module tss_ctrl
    import tss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  tss_stat_t stat,
    output tss_cmd_t  cmd
);

    tss_state_t state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       slot_free;

    assign slot_free = !ovalid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_START1;
            ST_START1: state_next = ST_WAIT1;
            ST_WAIT1:  if (stat.div_done) state_next = ST_START2;
            ST_START2: state_next = ST_WAIT2;
            ST_WAIT2:  if (stat.div_done) state_next = ST_MUL;
            ST_MUL:    state_next = ST_HOLD;
            ST_HOLD:   if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_START1: cmd.div_start = 1'b1;
            ST_WAIT1:  cmd.cap1 = stat.div_done;
            ST_START2:
            begin
                cmd.div_start = 1'b1;
                cmd.stage2    = 1'b1;
            end
            ST_WAIT2:
            begin
                cmd.stage2 = 1'b1;
                cmd.cap2   = stat.div_done;
            end
            ST_MUL:    cmd.mul = 1'b1;
            ST_HOLD:   cmd.load = slot_free;
            default:   ;
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.load)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

endmodule

// ===== rtl/core/tdma_superframe_slot_timer.sv =====
// TDMA superframe slot timer top level.
// Each accepted word passes through the launch, two division passes of a pair
// of bit-serial 32-bit dividers, the slot offset product and the output load.
// A new word is taken only after the last one is loaded; a result may wait in
// the output register while the next word is taken. Config writes are always accepted.
// Reset: rst_n async; slot count 100, slot length 1000, frame start 0, no result.
module tdma_superframe_slot_timer
    import tss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tss_cfg_if.sink      cfg,
    tss_item_if.sink     item_in,
    tss_result_if.source result_out
);

    tss_cmd_t    cmd;
    tss_stat_t   stat;
    tss_item_t   item;
    tss_result_t result;

    assign cfg.ready       = 1'b1;
    assign item.now_ms     = item_in.now_ms;
    assign item.query_slot = item_in.query_slot;
    assign item.advance    = item_in.advance;

    tss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_ready  (item_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tss_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

    assign result_out.active_slot      = result.active_slot;
    assign result_out.frame_elapsed    = result.frame_elapsed;
    assign result_out.slot_begin_ms    = result.slot_begin_ms;
    assign result_out.slot_finish_ms   = result.slot_finish_ms;
    assign result_out.frame_length_ms  = result.frame_length_ms;
    assign result_out.next_frame_start = result.next_frame_start;

endmodule

// ===== rtl/core/tss_checker.sv =====
// Port-level checker for the slot timer, bound to the top level.
module tss_checker
    import tss_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] slot_begin_ms,
    input logic [31:0] slot_finish_ms,
    input logic [31:0] next_frame_start
);

    logic [31:0] slot_span;

    assign slot_span = slot_finish_ms - slot_begin_ms;

    // one word in flight: engine is busy right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while engine busy");

    // slot span is the 16-bit slot length
    a_slot_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (slot_span[31:16] == 16'd0))
        else $error("slot span exceeds slot length range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(slot_begin_ms) && $stable(next_frame_start)))
        else $error("stalled result word changed");

endmodule

bind tdma_superframe_slot_timer tss_checker u_tss_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (item_in.valid),
    .in_ready         (item_in.ready),
    .out_valid        (result_out.valid),
    .out_ready        (result_out.ready),
    .slot_begin_ms    (result_out.slot_begin_ms),
    .slot_finish_ms   (result_out.slot_finish_ms),
    .next_frame_start (result_out.next_frame_start)
);
